>>> hdl/rk4co_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rk4co_pkg: shared types and helpers for the coupled oscillator integrator
// Payload structs, sequencer states, register and command codes, saturation.
// ----------------------------------------------------------------------------
package rk4co_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CFG_W         = 31;
  localparam int unsigned ACC_W         = 35;
  localparam int unsigned LANES         = 4;
  localparam int unsigned DIVISOR       = 6;
  localparam int unsigned NIB_W         = 4;
  localparam int unsigned DIV_W         = 36;
  localparam int unsigned DIV_STEPS     = DIV_W / NIB_W;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // register indexes (byte address bit 2)
  localparam logic REG_TIME_STEP  = 1'b0;
  localparam logic REG_INV_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DERIV,
    ST_ACC,
    ST_ADV,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_UPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               command;
    logic signed [31:0] load_pos_one;
    logic signed [31:0] load_pos_two;
    logic signed [31:0] load_vel_one;
    logic signed [31:0] load_vel_two;
  } req_t;

  typedef struct packed {
    logic signed [31:0] pos_one;
    logic signed [31:0] pos_two;
    logic signed [31:0] vel_one;
    logic signed [31:0] vel_two;
    logic               saturated;
  } res_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] val;
  } sat_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         tag;
    logic               hit;
    logic signed [31:0] val;
  } mul_res_t;

  // clamp a wide signed value to 32 bits, flag when clamped
  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t r;
    r.hit = 1'b0;
    r.val = x[31:0];
    if (x > 64'sd2147483647) begin
      r.hit = 1'b1;
      r.val = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r.hit = 1'b1;
      r.val = 32'sh80000000;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/rk4_coupled_oscillator_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_coupled_oscillator_step: fourth-order Runge-Kutta step of two coupled
// oscillators in signed fixed point with saturation.
// ----------------------------------------------------------------------------
// Requests enter on in_valid_i/in_stall_o and results leave on
// out_valid_o/out_stall_i; a transfer happens at a clock edge with valid
// high and stall low. A load request writes the state and returns it via
// the done state and the output register. A step request runs four
// derivative stages, the weighted average and the update through one
// shared multiplier and one radix-16 divide-by-six unit, in order the
// stages, one division per lane, the update and the posting of the result.
// The block holds in_stall_o high for the whole request. A result waits in
// the output register while the receiver stalls; the block takes the next
// request meanwhile and finishes it, but holds its result until the
// register frees up.
// Reset clears the state to zero, time_step to 0.1 and inv_length to 0.5.
// time_step lies at byte address 0, inv_length at 4; write them only while
// no request is in flight.
// ----------------------------------------------------------------------------
module rk4_coupled_oscillator_step #(
  parameter int unsigned FRAC_BITS = rk4co_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rk4co_pkg::req_t   in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rk4co_pkg::res_t        out_res_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam logic [30:0] DtReset  = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [30:0] InvReset = 31'(64'd1 << (FRAC_BITS - 1));
  localparam int unsigned Lanes    = rk4co_pkg::LANES;
  localparam int unsigned AccW     = rk4co_pkg::ACC_W;

  rk4co_pkg::state_e  state_d, state_q;
  logic [2:0]         cnt_d, cnt_q;
  logic [1:0]         stg_d, stg_q;
  logic [1:0]         idx_d, idx_q;
  logic signed [31:0] s_d [Lanes];
  logic signed [31:0] s_q [Lanes];
  logic signed [31:0] t_d [Lanes];
  logic signed [31:0] t_q [Lanes];
  logic signed [31:0] k_d [Lanes];
  logic signed [31:0] k_q [Lanes];
  logic signed [AccW-1:0] w_d [Lanes];
  logic signed [AccW-1:0] w_q [Lanes];
  logic               sat_d, sat_q;
  logic [30:0]        dt_q, inv_q;
  logic               out_valid_d, out_valid_q;
  rk4co_pkg::res_t    out_res_d, out_res_q;

  logic               mul_issue;
  logic [1:0]         mul_tag;
  logic [30:0]        mul_a;
  logic signed [31:0] mul_b;
  rk4co_pkg::mul_res_t mul_res;
  logic               div_start;
  logic               div_done;
  rk4co_pkg::sat_t    div_q;

  logic signed [33:0] diff_w, sum_w;
  logic signed [32:0] neg_w;
  rk4co_pkg::sat_t    diff_s, sum_s, neg_s, add_s;
  logic [30:0]        adv_h;
  logic               dbl;
  logic               hit;
  logic               cfg_wr;

  // ---------------- configuration port ----------------
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == rk4co_pkg::REG_INV_LENGTH) ? {1'b0, inv_q} : {1'b0, dt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q  <= DtReset;
      inv_q <= InvReset;
    end else if (cfg_wr) begin
      if (paddr[2] == rk4co_pkg::REG_TIME_STEP) dt_q <= pwdata[30:0];
      else                                      inv_q <= pwdata[30:0];
    end
  end

  // ---------------- shared units ----------------
  rk4co_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (mul_issue),
    .tag_i   (mul_tag),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .res_o   (mul_res)
  );

  rk4co_div6 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .w_i     (w_q[idx_q]),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // ---------------- datapath terms ----------------
  assign diff_w = (34'(t_q[0]) <<< 1) - 34'(t_q[1]);
  assign sum_w  = (34'(t_q[0]) <<< 1) + (34'(t_q[1]) <<< 1);
  assign diff_s = rk4co_pkg::sat32(64'(diff_w));
  assign sum_s  = rk4co_pkg::sat32(64'(sum_w));
  assign neg_w  = -33'(mul_res.val);
  assign neg_s  = rk4co_pkg::sat32(64'(neg_w));
  assign add_s  = rk4co_pkg::sat32(64'(s_q[mul_res.tag]) + 64'(mul_res.val));
  // last stage argument takes the full step
  assign adv_h  = (stg_q == 2'd2) ? dt_q : (dt_q >> 1);
  assign dbl    = (stg_q == 2'd1) || (stg_q == 2'd2);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    stg_d       = stg_q;
    idx_d       = idx_q;
    s_d         = s_q;
    t_d         = t_q;
    k_d         = k_q;
    w_d         = w_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    mul_issue   = 1'b0;
    mul_tag     = '0;
    mul_a       = inv_q;
    mul_b       = diff_s.val;
    div_start   = 1'b0;
    hit         = 1'b0;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      rk4co_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.command == rk4co_pkg::CMD_LOAD) begin
            s_d[0]  = in_req_i.load_pos_one;
            s_d[1]  = in_req_i.load_pos_two;
            s_d[2]  = in_req_i.load_vel_one;
            s_d[3]  = in_req_i.load_vel_two;
            sat_d   = 1'b0;
            state_d = rk4co_pkg::ST_DONE;
          end else begin
            t_d     = s_q;
            for (int n = 0; n < Lanes; n++) w_d[n] = '0;
            stg_d   = '0;
            cnt_d   = '0;
            sat_d   = 1'b0;
            state_d = rk4co_pkg::ST_DERIV;
          end
        end
      end

      rk4co_pkg::ST_DERIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'd0) begin
          mul_issue = 1'b1;
          mul_tag   = 2'd2;
          mul_b     = diff_s.val;
          hit       = diff_s.hit;
          k_d[0]    = t_q[2];
          k_d[1]    = t_q[3];
        end else if (cnt_q == 3'd1) begin
          mul_issue = 1'b1;
          mul_tag   = 2'd3;
          mul_b     = sum_s.val;
          hit       = sum_s.hit;
        end else begin
          cnt_d   = '0;
          state_d = rk4co_pkg::ST_ACC;
        end
        if (mul_res.valid) begin
          k_d[mul_res.tag] = neg_s.val;
          hit = hit | mul_res.hit | neg_s.hit;
        end
      end

      rk4co_pkg::ST_ACC: begin
        for (int n = 0; n < Lanes; n++) begin
          w_d[n] = w_q[n] + (dbl ? (AccW'(k_q[n]) <<< 1) : AccW'(k_q[n]));
        end
        if (stg_q == 2'd3) begin
          idx_d   = '0;
          state_d = rk4co_pkg::ST_DIV_GO;
        end else begin
          cnt_d   = '0;
          state_d = rk4co_pkg::ST_ADV;
        end
      end

      rk4co_pkg::ST_ADV, rk4co_pkg::ST_UPD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != 3'(Lanes)) begin
          mul_issue = 1'b1;
          mul_tag   = cnt_q[1:0];
          mul_a     = (state_q == rk4co_pkg::ST_UPD) ? dt_q : adv_h;
          mul_b     = k_q[cnt_q[1:0]];
        end else begin
          cnt_d = '0;
          if (state_q == rk4co_pkg::ST_UPD) begin
            state_d = rk4co_pkg::ST_DONE;
          end else begin
            stg_d   = stg_q + 1'b1;
            state_d = rk4co_pkg::ST_DERIV;
          end
        end
        if (mul_res.valid) begin
          if (state_q == rk4co_pkg::ST_UPD) s_d[mul_res.tag] = add_s.val;
          else                              t_d[mul_res.tag] = add_s.val;
          hit = mul_res.hit | add_s.hit;
        end
      end

      rk4co_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = rk4co_pkg::ST_DIV_WAIT;
      end

      rk4co_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          k_d[idx_q] = div_q.val;
          hit        = div_q.hit;
          if (idx_q == 2'(Lanes - 1)) begin
            cnt_d   = '0;
            state_d = rk4co_pkg::ST_UPD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = rk4co_pkg::ST_DIV_GO;
          end
        end
      end

      rk4co_pkg::ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_res_d.pos_one   = s_q[0];
          out_res_d.pos_two   = s_q[1];
          out_res_d.vel_one   = s_q[2];
          out_res_d.vel_two   = s_q[3];
          out_res_d.saturated = sat_q;
          state_d             = rk4co_pkg::ST_IDLE;
        end
      end

      default: state_d = rk4co_pkg::ST_IDLE;
    endcase

    if (hit) sat_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rk4co_pkg::ST_IDLE;
      cnt_q       <= '0;
      stg_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int n = 0; n < Lanes; n++) s_q[n] <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      stg_q       <= stg_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      s_q         <= s_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    k_q       <= k_d;
    w_q       <= w_d;
    sat_q     <= sat_d;
    out_res_q <= out_res_d;
  end

  assign in_stall_o  = (state_q != rk4co_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // ---------------- assertions ----------------
  a_post_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == rk4co_pkg::ST_DONE))
    else $error("result posted outside the done state");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == rk4co_pkg::ST_DIV_WAIT))
    else $error("divider finished while nobody waits for it");

  a_mul_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_res.valid |-> (state_q == rk4co_pkg::ST_DERIV || state_q == rk4co_pkg::ST_ADV ||
                       state_q == rk4co_pkg::ST_UPD))
    else $error("multiplier result dropped");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != rk4co_pkg::ST_IDLE))
    else $error("accepted request did not start");

endmodule
`default_nettype wire

>>> hdl/rk4co_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rk4co_mul: shared fixed point multiplier
// Registers the exact product of an unsigned step or gain with a signed value;
// the next cycle presents it floor-shifted and clamped, with its lane tag.
// ----------------------------------------------------------------------------
module rk4co_mul #(
  parameter int unsigned FRAC_BITS = rk4co_pkg::FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     issue_i,
  input  wire logic [1:0]               tag_i,
  input  wire logic [30:0]              a_i,
  input  wire logic signed [31:0]       b_i,
  output rk4co_pkg::mul_res_t           res_o
);

  logic signed [63:0] prod_d, prod_q;
  logic signed [63:0] shifted;
  logic [1:0]         tag_q;
  logic               vld_q;
  rk4co_pkg::sat_t    clamp;

  assign prod_d = 64'($signed({1'b0, a_i})) * 64'(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= prod_d;
      tag_q  <= tag_i;
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign shifted = prod_q >>> FRAC_BITS;
  assign clamp   = rk4co_pkg::sat32(shifted);

  assign res_o.valid = vld_q;
  assign res_o.tag   = tag_q;
  assign res_o.hit   = clamp.hit;
  assign res_o.val   = clamp.val;

endmodule
`default_nettype wire

>>> hdl/rk4co_div6.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rk4co_div6: divide the weighted stage sum by six
// Radix-16 long division of the magnitude, one nibble a cycle, quotient
// truncated toward zero and clamped to 32 bits.
// ----------------------------------------------------------------------------
module rk4co_div6 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [34:0]            w_i,
  output logic                               done_o,
  output rk4co_pkg::sat_t                    q_o
);

  localparam int unsigned CntW = $clog2(rk4co_pkg::DIV_STEPS);
  localparam int unsigned DivW = rk4co_pkg::DIV_W;

  logic signed [DivW-1:0] w_ext;
  logic [DivW-1:0]        mag_in;
  logic [DivW-1:0]        mag_d, mag_q;
  logic [DivW-1:0]        quo_d, quo_q;
  logic [2:0]             rem_d, rem_q;
  logic [CntW-1:0]        cnt_d, cnt_q;
  logic                   busy_d, busy_q;
  logic                   done_d, done_q;
  logic                   neg_d, neg_q;
  logic [6:0]             x;
  logic [3:0]             qd;
  logic signed [63:0]     q_signed;

  assign w_ext  = DivW'(w_i);
  assign mag_in = w_ext[DivW-1] ? DivW'(-w_ext) : w_ext;

  // one quotient digit from remainder and next nibble
  always_comb begin
    x  = {rem_q, mag_q[DivW-1 -: rk4co_pkg::NIB_W]};
    qd = '0;
    for (int j = 1; j < 16; j++) begin
      if (x >= 7'(j * rk4co_pkg::DIVISOR)) qd = 4'(j);
    end
  end

  always_comb begin
    mag_d  = mag_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      mag_d  = mag_in;
      quo_d  = '0;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      neg_d  = w_i[34];
    end else if (busy_q) begin
      mag_d = mag_q << rk4co_pkg::NIB_W;
      quo_d = {quo_q[DivW-1-rk4co_pkg::NIB_W:0], qd};
      rem_d = 3'(x - 7'(qd) * 7'(rk4co_pkg::DIVISOR));
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(rk4co_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign q_signed = neg_q ? -$signed(64'(quo_q)) : $signed(64'(quo_q));
  assign q_o      = rk4co_pkg::sat32(q_signed);
  assign done_o   = done_q;

endmodule
`default_nettype wire

>>> sim/rk4_coupled_oscillator_step_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_coupled_oscillator_step_tb: self-checking bench for the RK4 integrator
// Drives load and step requests through the valid/stall channel, mirrors the
// fixed-point integration in a local predictor and compares every result.
// Register settings change between phases, including the extremes.
// ----------------------------------------------------------------------------
module rk4_coupled_oscillator_step_tb;
  import rk4co_pkg::*;

  localparam int unsigned FRAC      = FRAC_BITS_DEF;
  localparam logic [31:0] REG_MASK  = 32'h7fffffff;
  localparam int unsigned SETTINGS_N = 10;
  localparam int unsigned PHASE_ITEMS = 155;
  localparam int unsigned STUCK_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned DIRECTED_ROWS = 16;

  typedef struct packed {
    logic check;
    req_t req;
    res_t want;
  } vector_row_t;

  typedef struct packed {
    logic [31:0] time_step;
    logic [31:0] inv_length;
  } reg_setting_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  req_t        in_req_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  res_t        out_res_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  rk4_coupled_oscillator_step uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // predictor copy of registers and oscillator state
  longint cfg_time_step  = 6554;
  longint cfg_inv_length = 32768;
  int     osc_state [4]  = '{0, 0, 0, 0};
  bit     clamp_hit;

  res_t        expected_states [$];
  bit          jitter_on     = 1'b1;
  int unsigned error_count   = 0;
  int unsigned steps_sent    = 0;
  int unsigned loads_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned clamped_seen  = 0;
  int unsigned setting_count = 0;
  int unsigned stuck_cycles  = 0;
  int unsigned long_hold     = 0;

  vector_row_t directed_rows [DIRECTED_ROWS] = '{
    '{1'b1, '{CMD_STEP, 32'sh0, 32'sh0, 32'sh0, 32'sh0},
            '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0}},
    '{1'b1, '{CMD_LOAD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
            '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0}},
    '{1'b0, '{CMD_STEP, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, '0},
    '{1'b1, '{CMD_LOAD, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000},
            '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0}},
    '{1'b0, '{CMD_STEP, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, '0},
    '{1'b1, '{CMD_LOAD, 32'sh00010000, 32'sh0, 32'sh0, 32'sh0},
            '{32'sh00010000, 32'sh0, 32'sh0, 32'sh0, 1'b0}},
    '{1'b0, '{CMD_STEP, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, '0},
    '{1'b0, '{CMD_STEP, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, '0},
    '{1'b1, '{CMD_LOAD, 32'shaaaaaaaa, 32'sh55555555, 32'sh55555555, 32'shaaaaaaaa},
            '{32'shaaaaaaaa, 32'sh55555555, 32'sh55555555, 32'shaaaaaaaa, 1'b0}},
    '{1'b1, '{CMD_LOAD, 32'sh55555555, 32'shaaaaaaaa, 32'shaaaaaaaa, 32'sh55555555},
            '{32'sh55555555, 32'shaaaaaaaa, 32'shaaaaaaaa, 32'sh55555555, 1'b0}},
    '{1'b0, '{CMD_STEP, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, '0},
    '{1'b1, '{CMD_LOAD, 32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh0},
            '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh0, 1'b0}},
    '{1'b0, '{CMD_STEP, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, '0},
    '{1'b1, '{CMD_LOAD, 32'shffff0000, 32'sh00020000, 32'sh7fffffff, 32'sh80000000},
            '{32'shffff0000, 32'sh00020000, 32'sh7fffffff, 32'sh80000000, 1'b0}},
    // load fields of a step are don't-care
    '{1'b0, '{CMD_STEP, 32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff},
            '0},
    '{1'b0, '{CMD_STEP, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp32(longint x);
    if (x > 64'sd2147483647) begin
      clamp_hit = 1'b1;
      return 32'sh7fffffff;
    end
    if (x < -64'sd2147483648) begin
      clamp_hit = 1'b1;
      return 32'sh80000000;
    end
    return int'(x);
  endfunction

  // floor shift: >>> on a signed longint rounds toward minus infinity
  function automatic int fx_mul(longint a, longint b);
    return clamp32((a * b) >>> FRAC);
  endfunction

  function automatic int spring_accel(longint lin);
    return clamp32(-longint'(fx_mul(cfg_inv_length, clamp32(lin))));
  endfunction

  function automatic res_t advance_oscillator(req_t req);
    int     stage_in [4];
    int     slope [4][4];
    longint h;
    longint w;
    res_t   o;
    clamp_hit = 1'b0;
    if (req.command == CMD_LOAD) begin
      osc_state = '{req.load_pos_one, req.load_pos_two, req.load_vel_one, req.load_vel_two};
    end else begin
      stage_in = osc_state;
      for (int st = 0; st < 4; st++) begin
        slope[st][0] = stage_in[2];
        slope[st][1] = stage_in[3];
        slope[st][2] = spring_accel(2 * longint'(stage_in[0]) - longint'(stage_in[1]));
        slope[st][3] = spring_accel(2 * longint'(stage_in[0]) + 2 * longint'(stage_in[1]));
        // half step for stages two and three, full step for stage four
        h = (st == 2) ? cfg_time_step : (cfg_time_step >> 1);
        if (st < 3)
          for (int n = 0; n < 4; n++)
            stage_in[n] = clamp32(longint'(osc_state[n]) + longint'(fx_mul(h, slope[st][n])));
      end
      for (int n = 0; n < 4; n++) begin
        w = longint'(slope[0][n]) + 2 * longint'(slope[1][n])
          + 2 * longint'(slope[2][n]) + longint'(slope[3][n]);
        osc_state[n] = clamp32(longint'(osc_state[n])
                     + longint'(fx_mul(cfg_time_step, clamp32(w / 6))));
      end
    end
    o.pos_one   = osc_state[0];
    o.pos_two   = osc_state[1];
    o.vel_one   = osc_state[2];
    o.vel_two   = osc_state[3];
    o.saturated = clamp_hit;
    return o;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // mostly moderate values, some full-range words and some rails
  function automatic logic signed [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 75) return int'($urandom_range(32'h00200000)) - int'(32'h00100000);
    if (roll < 95) return $urandom;
    case ($urandom_range(3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic send_request(input req_t req, input logic check, input res_t want);
    res_t predicted;
    while (jitter_on && $urandom_range(99) < 10) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = req;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    predicted = advance_oscillator(req);
    expected_states.push_back(check ? want : predicted);
    if (req.command == CMD_STEP) steps_sent++;
    else loads_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (expected_states.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(input logic index, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {index, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (index == REG_TIME_STEP) cfg_time_step = longint'(value & REG_MASK);
    else cfg_inv_length = longint'(value & REG_MASK);
  endtask

  task automatic check_register(input logic index, input longint want);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {index, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata !== want[31:0])
      flag_error($sformatf("register %0d read %h, expected %h", index, prdata, want[31:0]));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    req_t        req;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        // stray request with arbitrary content
        req = {$urandom_range(1), $urandom, $urandom, $urandom, $urandom};
        send_request(req, 1'b0, '0);
        sent++;
      end else begin
        req = {CMD_LOAD, pick_value(), pick_value(), pick_value(), pick_value()};
        send_request(req, 1'b0, '0);
        sent++;
        run_len = $urandom_range(12, 1);
        repeat (run_len) begin
          req = {CMD_STEP, $urandom, $urandom, $urandom, $urandom};
          send_request(req, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // receiver: short random stalls plus a rare long hold
  always @(negedge clk_i) begin
    if (!jitter_on) begin
      out_stall_i <= 1'b0;
    end else if (long_hold != 0) begin
      long_hold = long_hold - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(999) < 2) begin
      long_hold = $urandom_range(200, 100);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < 10);
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (out_res_o.saturated === 1'b1) clamped_seen++;
      if (expected_states.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing expected: %h",
                             results_seen, out_res_o));
      end else begin
        want = expected_states.pop_front();
        if (out_res_o.pos_one !== want.pos_one || out_res_o.pos_two !== want.pos_two ||
            out_res_o.vel_one !== want.vel_one || out_res_o.vel_two !== want.vel_two ||
            out_res_o.saturated !== want.saturated)
          flag_error($sformatf({"result %0d: got p1=%h p2=%h v1=%h v2=%h sat=%b, ",
                                "expected p1=%h p2=%h v1=%h v2=%h sat=%b"}, results_seen,
                               out_res_o.pos_one, out_res_o.pos_two, out_res_o.vel_one,
                               out_res_o.vel_two, out_res_o.saturated, want.pos_one,
                               want.pos_two, want.vel_one, want.vel_two, want.saturated));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("no request or result moved for %0d cycles", STUCK_LIMIT);
        $display("rk4_coupled_oscillator_step_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    reg_setting_t settings [SETTINGS_N];
    settings[0] = '{32'd6554, 32'd32768};
    settings[1] = '{32'd0, 32'd0};
    settings[2] = '{32'hffffffff, 32'hffffffff};
    settings[3] = '{32'd1, 32'd1};
    settings[4] = '{32'd13107, 32'd65536};
    settings[5] = '{32'd65536, 32'd131072};
    for (int i = 6; i < SETTINGS_N; i++)
      settings[i] = '{$urandom_range(32'h18000) | ($urandom & 32'h80000000),
                      $urandom_range(32'h50000) | ($urandom & 32'h80000000)};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values, then the directed table
    check_register(REG_TIME_STEP, cfg_time_step);
    check_register(REG_INV_LENGTH, cfg_inv_length);
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_request(directed_rows[i].req, directed_rows[i].check, directed_rows[i].want);

    for (int s = 0; s < SETTINGS_N; s++) begin
      wait_drained();
      if (s != 0) begin
        write_register(REG_TIME_STEP, settings[s].time_step);
        write_register(REG_INV_LENGTH, settings[s].inv_length);
        check_register(REG_TIME_STEP, cfg_time_step);
        check_register(REG_INV_LENGTH, cfg_inv_length);
      end
      setting_count++;
      // one phase runs back to back on both sides
      jitter_on = (s != 4);
      run_random_phase(PHASE_ITEMS);
    end

    jitter_on = 1'b1;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("covered %0d requests (%0d steps, %0d loads) over %0d register settings",
             steps_sent + loads_sent, steps_sent, loads_sent, setting_count);
    $display("%0d results checked, %0d of them saturated, %0d mismatches",
             results_seen, clamped_seen, error_count);
    if (error_count == 0) begin
      $display("rk4_coupled_oscillator_step_tb: PASS");
    end else begin
      $display("rk4_coupled_oscillator_step_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
hdl/rk4co_pkg.sv
hdl/rk4co_mul.sv
hdl/rk4co_div6.sv
hdl/rk4_coupled_oscillator_step.sv
sim/rk4_coupled_oscillator_step_tb.sv
